// ===== hdl/byte_keyed_48_slot_child_table_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the child table core
// Clocked assertion helpers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef BYTE_KEYED_48_SLOT_CHILD_TABLE_CORE_MACROS_SVH
`define BYTE_KEYED_48_SLOT_CHILD_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge outside reset.
`define BKCT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at every rising edge outside reset.
`define BKCT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define BKCT_ASSERT(label, clk, rst, prop, msg)

`define BKCT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/bkct_pkg.sv =====
// ----------------------------------------------------------------------------
// Child table package
// Request and response types, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package bkct_pkg;

  localparam int KEYS = 256;

  // Request codes.
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_LOOKUP = 3'd1;
  localparam logic [2:0] REQ_GE     = 3'd2;
  localparam logic [2:0] REQ_NEXT   = 3'd3;
  localparam logic [2:0] REQ_MIN    = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  key;
    logic [31:0] child_value;
  } bkct_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_key;
    logic        equal_match;
    logic [31:0] child_out;
  } bkct_rsp_t;

  // Result of the key search between the encoder and the controller.
  typedef struct packed {
    logic       found;
    logic [7:0] pos;
  } bkct_hit_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_SCAN2,
    S_IDX,
    S_HND
  } bkct_state_t;

endpackage

// ===== hdl/byte_keyed_48_slot_child_table_core.sv =====
// ----------------------------------------------------------------------------
// Byte-keyed child table core
// Radix-tree node with a 256-entry key index pointing into SLOTS child slots.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on rsp for exactly one cycle with done high, and the receiver cannot
// hold it off. Insert, lookup of a missing key and searches that find nothing
// pass through the two-stage key encoder and the registered read of the index
// memory before the next request can be taken; lookups and searches that find
// a key also wait for the registered read of the handle memory. Occupancy is
// held in flip-flops cleared by reset, so the block is ready right after reset
// with no clearing pass.
`include "byte_keyed_48_slot_child_table_core_macros.svh"

module byte_keyed_48_slot_child_table_core
  import bkct_pkg::*;
#(
  parameter int SLOTS       = 48,
  parameter int HANDLE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  bkct_req_t req,
  output logic      done,
  output bkct_rsp_t rsp
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  bkct_state_t state, state_next;

  bkct_req_t            req_r;
  logic [KEYS-1:0]      present;
  logic [SLOTS-1:0]     used;
  logic [CW-1:0]        entry_count;
  logic [SW-1:0]        free_slot, free_slot_next;
  logic                 has_free, has_free_next;
  logic                 key_hit;
  logic [7:0]           pos, pos_next;
  logic                 found, found_next;
  logic                 done_next;
  bkct_rsp_t            rsp_next;
  bkct_hit_t            hit;
  logic [7:0]           from;
  logic                 none;

  // Memories and their ports.
  logic [SW-1:0]          key_slot_index [KEYS];
  logic [HANDLE_BITS-1:0] slot_handles   [SLOTS];
  logic [7:0]             idx_raddr;
  logic [SW-1:0]          idx_q;
  logic                   idx_we;
  logic [SW-1:0]          hnd_addr;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic                   hnd_we;
  logic                   ins_new;

  logic [95:0]                 val_wide;
  logic [HANDLE_BITS-1:0]      val_h;
  logic [HANDLE_BITS+31:0]     hnd_wide;
  logic [31:0]                 hnd_out;
  logic [HANDLE_BITS+31:0]     val_back_wide;
  logic [31:0]                 val_out;

  // Handle width conversion in both directions.
  assign val_wide      = {64'd0, req_r.child_value};
  assign val_h         = val_wide[HANDLE_BITS-1:0];
  assign hnd_wide      = {32'd0, hnd_q};
  assign hnd_out       = hnd_wide[31:0];
  assign val_back_wide = {32'd0, val_h};
  assign val_out       = val_back_wide[31:0];

  assign busy = (state != S_IDLE);

  // Start point of the key search for each request type.
  always_comb begin
    from = 8'd0;
    none = 1'b1;
    case (req_r.req_type)
      REQ_GE: begin
        from = req_r.key;
        none = 1'b0;
      end
      REQ_NEXT: begin
        from = req_r.key + 8'd1;
        none = (req_r.key == 8'hFF);
      end
      REQ_MIN: begin
        from = 8'd0;
        none = 1'b0;
      end
      default: begin
        from = 8'd0;
        none = 1'b1;
      end
    endcase
  end

  bkct_key_search u_search (
    .clk     (clk),
    .present (present),
    .from    (from),
    .none    (none),
    .hit     (hit)
  );

  // Lowest free slot.
  always_comb begin
    has_free_next  = ~&used;
    free_slot_next = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!used[s]) begin
        free_slot_next = SW'(s);
      end
    end
  end

  // Controller: next state, memory controls and the result.
  always_comb begin
    state_next = state;
    pos_next   = pos;
    found_next = found;
    done_next  = 1'b0;
    rsp_next   = '{status: ST_NOT_FOUND, found_key: 8'd0, equal_match: 1'b0,
                   child_out: 32'd0};
    idx_raddr  = pos;
    idx_we     = 1'b0;
    hnd_we     = 1'b0;
    hnd_addr   = idx_q;
    ins_new    = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN1;
        end
      end
      S_SCAN1: begin
        state_next = S_SCAN2;
      end
      S_SCAN2: begin
        case (req_r.req_type)
          REQ_INSERT, REQ_LOOKUP: begin
            pos_next   = req_r.key;
            found_next = key_hit;
          end
          REQ_GE, REQ_NEXT, REQ_MIN: begin
            pos_next   = hit.pos;
            found_next = hit.found;
          end
          default: begin
            pos_next   = 8'd0;
            found_next = 1'b0;
          end
        endcase
        idx_raddr  = pos_next;
        state_next = S_IDX;
      end
      S_IDX: begin
        if (req_r.req_type == REQ_INSERT) begin
          // Insert: overwrite an existing slot, claim the lowest free one, or report full.
          done_next          = 1'b1;
          state_next         = S_IDLE;
          rsp_next.found_key = req_r.key;
          if (found) begin
            hnd_we             = 1'b1;
            hnd_addr           = idx_q;
            rsp_next.status    = ST_OK;
            rsp_next.child_out = val_out;
          end else if (entry_count >= CW'(SLOTS) || !has_free) begin
            rsp_next.status = ST_FULL;
          end else begin
            hnd_we             = 1'b1;
            hnd_addr           = free_slot;
            idx_we             = 1'b1;
            ins_new            = 1'b1;
            rsp_next.status    = ST_OK;
            rsp_next.child_out = val_out;
          end
        end else if (found) begin
          hnd_addr   = idx_q;
          state_next = S_HND;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HND: begin
        done_next            = 1'b1;
        state_next           = S_IDLE;
        rsp_next.status      = ST_OK;
        rsp_next.found_key   = pos;
        rsp_next.equal_match = (req_r.req_type == REQ_GE) && (pos == req_r.key);
        rsp_next.child_out   = hnd_out;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      present     <= '0;
      used        <= '0;
      entry_count <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (ins_new) begin
        present[req_r.key]      <= 1'b1;
        used[free_slot]         <= 1'b1;
        entry_count             <= entry_count + CW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_r <= req;
    end
    if (state == S_SCAN1) begin
      free_slot <= free_slot_next;
      has_free  <= has_free_next;
      key_hit   <= present[req_r.key];
    end
    pos   <= pos_next;
    found <= found_next;
    rsp   <= rsp_next;
  end

  // Key index memory.
  always_ff @(posedge clk) begin
    if (idx_we) begin
      key_slot_index[req_r.key] <= free_slot;
    end
    idx_q <= key_slot_index[idx_raddr];
  end

  // Child handle memory.
  always_ff @(posedge clk) begin
    if (hnd_we) begin
      slot_handles[hnd_addr] <= val_h;
    end
    hnd_q <= slot_handles[hnd_addr];
  end

  // Checks on the controller and the occupancy bookkeeping.
  `BKCT_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result shown while still busy")
  `BKCT_ASSERT(a_count_used, clk, rst, $countones(used) == 32'(entry_count), "count mismatch")
  `BKCT_ASSERT(a_count_max, clk, rst, entry_count <= CW'(SLOTS), "entry count above slots")
  `BKCT_ASSERT_IMPL(a_full_ok, clk, rst, done && rsp.status == ST_FULL,
                    entry_count == CW'(SLOTS), "full with free slots")
  `BKCT_ASSERT(a_accept, clk, rst, (start && !busy) |=> (busy && !done),
               "accept did not start work")

endmodule

// ===== hdl/bkct_key_search.sv =====
// ----------------------------------------------------------------------------
// Key search encoder
// Two-level priority encoder over the 256 present bits, starting at a key.
// ----------------------------------------------------------------------------
module bkct_key_search
  import bkct_pkg::*;
(
  input  logic            clk,
  input  logic [KEYS-1:0] present,
  input  logic [7:0]      from,
  input  logic            none,
  output bkct_hit_t       hit
);

  logic [KEYS-1:0] masked;
  logic [15:0]     grp_any;
  logic [3:0]      grp_low [16];
  logic [15:0]     grp_any_next;
  logic [3:0]      grp_low_next [16];

  // Keep only present keys at or above the start key.
  always_comb begin
    for (int k = 0; k < KEYS; k++) begin
      masked[k] = present[k] && (8'(k) >= from) && !none;
    end
  end

  // First level: lowest set bit within each group of sixteen keys.
  always_comb begin
    for (int g = 0; g < 16; g++) begin
      grp_any_next[g] = |masked[g*16 +: 16];
      grp_low_next[g] = 4'd0;
      for (int b = 15; b >= 0; b--) begin
        if (masked[g*16 + b]) begin
          grp_low_next[g] = 4'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= grp_any_next;
    for (int g = 0; g < 16; g++) begin
      grp_low[g] <= grp_low_next[g];
    end
  end

  // Second level: lowest group that holds a key.
  always_comb begin
    hit.found = |grp_any;
    hit.pos   = 8'd0;
    for (int g = 15; g >= 0; g--) begin
      if (grp_any[g]) begin
        hit.pos = {4'(g), grp_low[g]};
      end
    end
  end

endmodule
